// ===== hdl/first_fit_boundary_tag_allocator_macros.svh =====
// Assertion helpers used by the allocator RTL.
`ifndef FIRST_FIT_BOUNDARY_TAG_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BOUNDARY_TAG_ALLOCATOR_MACROS_SVH

// Checked only outside reset.
`define FFBT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define FFBT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/ffbt_pkg.sv =====
package ffbt_pkg;

  localparam int DEF_HEAP_BYTES = 16384;
  localparam int DEF_TAG_BYTES  = 4;

  localparam int APB_ADDR_W = 2;
  localparam int APB_DATA_W = 32;

  localparam logic [APB_ADDR_W-1:0] REG_HEAP_BASE = 2'd0;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLR,
    ST_INIT_HDR,
    ST_INIT_TRL,
    ST_A_ROUND,
    ST_A_NEED,
    ST_W_RD,
    ST_W_CHK,
    ST_A_SPLIT0,
    ST_A_SPLIT1,
    ST_A_SPLIT2,
    ST_A_SPLIT3,
    ST_A_WHOLE0,
    ST_A_WHOLE1,
    ST_F_HDR,
    ST_F_CHK,
    ST_F_TRL_RD,
    ST_F_TRL_CHK,
    ST_F_MARK0,
    ST_F_MARK1,
    ST_F_NX,
    ST_F_NX_CHK,
    ST_F_PV,
    ST_F_PV_CHK,
    ST_F_PV_RD,
    ST_F_PV_HDR,
    ST_F_PMARK0,
    ST_F_PMARK1,
    ST_F_OK,
    ST_FAIL
  } state_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic direct;
  } mem_ctl_t;

endpackage

// ===== hdl/ffbt_tagmem.sv =====
module ffbt_tagmem
  import ffbt_pkg::*;
#(
  parameter int HEAP_BYTES = DEF_HEAP_BYTES,
  parameter int TAG_BYTES  = DEF_TAG_BYTES
) (
  input  logic                                                   clk,
  input  mem_ctl_t                                               ctl,
  input  logic [$clog2((HEAP_BYTES/TAG_BYTES)*TAG_BYTES+1):0]    baddr,
  input  logic [$clog2(HEAP_BYTES/TAG_BYTES)-1:0]                dword,
  input  logic [$clog2((HEAP_BYTES/TAG_BYTES)*TAG_BYTES+1)-1:0]  wdata,
  output logic [$clog2((HEAP_BYTES/TAG_BYTES)*TAG_BYTES+1)-1:0]  rdata,
  output logic [$clog2((HEAP_BYTES/TAG_BYTES)*TAG_BYTES+1):0]    word
);

  localparam int HEAP_WORDS = HEAP_BYTES / TAG_BYTES;
  localparam int HEAP_SPAN  = HEAP_WORDS * TAG_BYTES;
  localparam int TAG_W      = $clog2(HEAP_SPAN + 1);
  localparam int WORD_W     = $clog2(HEAP_WORDS);
  localparam int AW         = TAG_W + 1;
  localparam int K          = AW + $clog2(TAG_BYTES);
  localparam int PW         = AW + K;
  localparam int RECIP      = (2 ** K) / TAG_BYTES + 1;

  logic [TAG_W-1:0]  mem [HEAP_WORDS];
  logic [PW-1:0]     prod;
  logic [WORD_W-1:0] idx;

  // byte offset to word index: reciprocal multiply, exact for all AW-bit offsets
  assign prod = PW'(baddr) * PW'(RECIP);
  assign word = prod[PW-1:K];
  assign idx  = ctl.direct ? dword : word[WORD_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[idx] <= wdata;
    end
    if (ctl.rd) begin
      rdata <= mem[idx];
    end
  end

endmodule

// ===== hdl/ffbt_seq.sv =====
`include "first_fit_boundary_tag_allocator_macros.svh"

module ffbt_seq
  import ffbt_pkg::*;
#(
  parameter int HEAP_BYTES = DEF_HEAP_BYTES,
  parameter int TAG_BYTES  = DEF_TAG_BYTES
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  logic                                                   start,
  input  logic                                                   func,
  input  logic [14:0]                                            request_size,
  input  logic [31:0]                                            payload_addr,
  input  logic [31:0]                                            heap_base,
  output logic                                                   busy,
  output logic                                                   done,
  output logic [31:0]                                            payload_address,
  output logic                                                   success,
  output mem_ctl_t                                               ctl,
  output logic [$clog2((HEAP_BYTES/TAG_BYTES)*TAG_BYTES+1):0]    baddr,
  output logic [$clog2(HEAP_BYTES/TAG_BYTES)-1:0]                dword,
  output logic [$clog2((HEAP_BYTES/TAG_BYTES)*TAG_BYTES+1)-1:0]  wdata,
  input  logic [$clog2((HEAP_BYTES/TAG_BYTES)*TAG_BYTES+1)-1:0]  rdata,
  input  logic [$clog2((HEAP_BYTES/TAG_BYTES)*TAG_BYTES+1):0]    word
);

  localparam int HEAP_WORDS = HEAP_BYTES / TAG_BYTES;
  localparam int HEAP_SPAN  = HEAP_WORDS * TAG_BYTES;
  localparam int TAG_W      = $clog2(HEAP_SPAN + 1);
  localparam int WORD_W     = $clog2(HEAP_WORDS);
  localparam int AW         = TAG_W + 1;
  localparam int CW         = WORD_W + 1;
  localparam int NW         = TAG_W + 2;

  localparam logic [TAG_W-1:0]  SPAN_V  = TAG_W'(HEAP_SPAN);
  localparam logic [TAG_W-1:0]  TB_V    = TAG_W'(TAG_BYTES);
  localparam logic [TAG_W-1:0]  TB3_V   = TAG_W'(3 * TAG_BYTES);
  localparam logic [AW-1:0]     TB_A    = AW'(TAG_BYTES);
  localparam logic [NW-1:0]     TB_N    = NW'(TAG_BYTES);
  localparam logic [CW-1:0]     WORDS_V = CW'(HEAP_WORDS);
  localparam logic [WORD_W-1:0] LAST_W  = WORD_W'(HEAP_WORDS - 1);

  state_t state, state_next;

  logic [CW-1:0]    cnt;
  logic [TAG_W-1:0] off, size, hv, psize, rem, q, req_q;
  logic [NW-1:0]    need;
  logic             ph;

  logic [TAG_W-1:0] rd_size, rem_calc, nx, total;
  logic [31:0]      off32;
  logic             emit, emit_ok;
  logic             w_fits, w_take, f_bad, nx_take, pv_take, ph_hdr_ok;

  assign busy     = (state != ST_IDLE);
  assign rd_size  = {rdata[TAG_W-1:1], 1'b0};
  assign rem_calc = rd_size - need[TAG_W-1:0];
  assign nx       = off + size;
  assign total    = psize + size;
  assign off32    = payload_addr - heap_base - 32'(TAG_BYTES);

  assign w_fits = (rd_size != '0) && (rd_size <= SPAN_V - off);
  assign w_take = !rdata[0] && (NW'(rd_size) >= need);

  // offset alignment, header size range, trailer below heap start
  assign f_bad = (NW'(q) * TB_N != NW'(off)) || (rd_size == '0) ||
                 (rd_size > SPAN_V - off) || ((AW'(off) + AW'(rd_size)) < TB_A);

  assign nx_take   = (rd_size != '0) && (rd_size <= SPAN_V - nx) && !rdata[0];
  assign pv_take   = (rd_size != '0) && (rd_size <= off);
  assign ph_hdr_ok = !rdata[0] && (rd_size == psize);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= emit;
      if (state == ST_CLR || state == ST_W_CHK) begin
        cnt <= cnt + 1'b1;
      end else if (state == ST_A_NEED) begin
        cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      success         <= emit_ok;
      payload_address <= (emit_ok && state != ST_F_OK) ?
                         heap_base + 32'(off) + 32'(TAG_BYTES) : '0;
    end
    unique case (state)
      ST_IDLE: begin
        req_q <= TAG_W'(request_size);
        off   <= off32[TAG_W-1:0];
      end
      ST_A_ROUND: q <= word[TAG_W-1:0];
      ST_A_NEED: begin
        need <= NW'(q) * TB_N + (TB_N << 1);
        off  <= '0;
      end
      ST_W_CHK: begin
        if (w_take) begin
          size <= rd_size;
          rem  <= rem_calc;
        end else begin
          off <= off + rd_size;
        end
      end
      ST_F_HDR: q <= word[TAG_W-1:0];
      ST_F_CHK: begin
        hv   <= rdata;
        size <= rd_size;
        ph   <= 1'b0;
      end
      ST_F_NX_CHK: begin
        if (nx_take) begin
          size <= size + rd_size;
          ph   <= 1'b1;
        end
      end
      ST_F_PV_CHK: psize <= rd_size;
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    baddr      = '0;
    dword      = '0;
    wdata      = '0;
    emit       = 1'b0;
    emit_ok    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (func == FUNC_FREE) begin
            state_next = (off32 >= 32'(HEAP_SPAN)) ? ST_FAIL : ST_F_HDR;
          end else begin
            state_next = (32'(request_size) >= 32'(HEAP_SPAN)) ? ST_FAIL : ST_A_ROUND;
          end
        end
      end
      ST_CLR: begin
        ctl.wr     = 1'b1;
        ctl.direct = 1'b1;
        dword      = cnt[WORD_W-1:0];
        if (cnt == WORDS_V - 1'b1) begin
          state_next = ST_INIT_HDR;
        end
      end
      ST_INIT_HDR: begin
        ctl.wr     = 1'b1;
        ctl.direct = 1'b1;
        wdata      = SPAN_V;
        state_next = ST_INIT_TRL;
      end
      ST_INIT_TRL: begin
        ctl.wr     = 1'b1;
        ctl.direct = 1'b1;
        dword      = LAST_W;
        wdata      = SPAN_V;
        state_next = ST_IDLE;
      end
      ST_A_ROUND: begin
        baddr      = AW'(req_q) + TB_A - 1'b1;
        state_next = ST_A_NEED;
      end
      ST_A_NEED: state_next = ST_W_RD;
      ST_W_RD: begin
        if (cnt == WORDS_V || off >= SPAN_V) begin
          state_next = ST_FAIL;
        end else begin
          ctl.rd     = 1'b1;
          baddr      = AW'(off);
          state_next = ST_W_CHK;
        end
      end
      ST_W_CHK: begin
        if (!w_fits) begin
          state_next = ST_FAIL;
        end else if (w_take) begin
          state_next = (rem_calc >= TB3_V) ? ST_A_SPLIT0 : ST_A_WHOLE0;
        end else begin
          state_next = ST_W_RD;
        end
      end
      ST_A_SPLIT0: begin
        ctl.wr     = 1'b1;
        baddr      = AW'(off);
        wdata      = need[TAG_W-1:0] | TAG_W'(1);
        state_next = ST_A_SPLIT1;
      end
      ST_A_SPLIT1: begin
        ctl.wr     = 1'b1;
        baddr      = AW'(off) + AW'(need[TAG_W-1:0]) - TB_A;
        wdata      = need[TAG_W-1:0] | TAG_W'(1);
        state_next = ST_A_SPLIT2;
      end
      ST_A_SPLIT2: begin
        ctl.wr     = 1'b1;
        baddr      = AW'(off) + AW'(need[TAG_W-1:0]);
        wdata      = rem;
        state_next = ST_A_SPLIT3;
      end
      ST_A_SPLIT3: begin
        ctl.wr     = 1'b1;
        baddr      = AW'(off) + AW'(size) - TB_A;
        wdata      = rem;
        emit       = 1'b1;
        emit_ok    = 1'b1;
        state_next = ST_IDLE;
      end
      ST_A_WHOLE0: begin
        ctl.wr     = 1'b1;
        baddr      = AW'(off);
        wdata      = size | TAG_W'(1);
        state_next = ST_A_WHOLE1;
      end
      ST_A_WHOLE1: begin
        ctl.wr     = 1'b1;
        baddr      = AW'(off) + AW'(size) - TB_A;
        wdata      = size | TAG_W'(1);
        emit       = 1'b1;
        emit_ok    = 1'b1;
        state_next = ST_IDLE;
      end
      ST_F_HDR: begin
        ctl.rd     = 1'b1;
        baddr      = AW'(off);
        state_next = ST_F_CHK;
      end
      ST_F_CHK: state_next = f_bad ? ST_FAIL : ST_F_TRL_RD;
      ST_F_TRL_RD: begin
        ctl.rd     = 1'b1;
        baddr      = AW'(off) + AW'(size) - TB_A;
        state_next = ST_F_TRL_CHK;
      end
      ST_F_TRL_CHK: state_next = (rdata != hv) ? ST_FAIL : ST_F_MARK0;
      ST_F_MARK0: begin
        ctl.wr = 1'b1;
        baddr  = AW'(off);
        wdata  = size;
        if (size >= TB_V) begin
          state_next = ST_F_MARK1;
        end else begin
          state_next = ph ? ST_F_PV : ST_F_NX;
        end
      end
      ST_F_MARK1: begin
        ctl.wr     = 1'b1;
        baddr      = AW'(off) + AW'(size) - TB_A;
        wdata      = size;
        state_next = ph ? ST_F_PV : ST_F_NX;
      end
      ST_F_NX: begin
        if (AW'(off) + AW'(size) < AW'(SPAN_V)) begin
          ctl.rd     = 1'b1;
          baddr      = AW'(nx);
          state_next = ST_F_NX_CHK;
        end else begin
          state_next = ST_F_PV;
        end
      end
      ST_F_NX_CHK: state_next = nx_take ? ST_F_MARK0 : ST_F_PV;
      ST_F_PV: begin
        if (off != '0) begin
          ctl.rd     = 1'b1;
          baddr      = AW'(off) - TB_A;
          state_next = ST_F_PV_CHK;
        end else begin
          state_next = ST_F_OK;
        end
      end
      ST_F_PV_CHK: state_next = pv_take ? ST_F_PV_RD : ST_F_OK;
      ST_F_PV_RD: begin
        ctl.rd     = 1'b1;
        baddr      = AW'(off - psize);
        state_next = ST_F_PV_HDR;
      end
      ST_F_PV_HDR: state_next = ph_hdr_ok ? ST_F_PMARK0 : ST_F_OK;
      ST_F_PMARK0: begin
        ctl.wr     = 1'b1;
        baddr      = AW'(off - psize);
        wdata      = total;
        state_next = (total >= TB_V) ? ST_F_PMARK1 : ST_F_OK;
      end
      ST_F_PMARK1: begin
        ctl.wr     = 1'b1;
        baddr      = AW'(off) + AW'(size) - TB_A;
        wdata      = total;
        state_next = ST_F_OK;
      end
      ST_F_OK: begin
        emit       = 1'b1;
        emit_ok    = 1'b1;
        state_next = ST_IDLE;
      end
      ST_FAIL: begin
        emit       = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `FFBT_ASSERT(a_done_single, done |=> !done, "result strobe held two cycles")
  `FFBT_ASSERT(a_done_idle, done |-> !busy, "result shown while still busy")
  `FFBT_ASSERT(a_fail_zero, done && !success |-> payload_address == '0,
               "failed request returned an address")
  `FFBT_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted request did not start")
  `FFBT_ASSERT(a_idle_no_write, !busy |-> !ctl.wr, "tag write while idle")
  `FFBT_ASSERT_ALWAYS(a_reset_clear, rst |=> busy && !done, "reset did not start clearing")

endmodule

// ===== hdl/first_fit_boundary_tag_allocator.sv =====
// First-fit boundary-tag heap allocator.
// Requests: drive func, request_size and payload_addr with start; a request is
// taken on a rising edge with start high and busy low. busy stays high until
// the result is out. The result (payload_address, success) is on the ports
// for exactly one cycle with done high; the receiver cannot stall it.
// Allocate: setup states A_ROUND and A_NEED, then per block walked one tag read
// from the single-port tag memory (W_RD) and its check (W_CHK), then 2 or 4
// tag writes. A walk that finds no fit ends in FAIL; a request at or above the
// heap size goes from idle straight to FAIL. Free: checks the tags, marks the
// block free and merges it with free neighbours. done is high in the cycle
// after the last busy cycle. The tag memory port is the limit: one access per
// cycle. A new request can be taken in the cycle that done is high.
// heap_base is to be written over the APB port (byte address 0) only while
// idle; the block does not enforce it. Reset (rst, synchronous) clears the
// tag memory, one word per cycle, then writes the tags of one free block
// spanning the heap with busy high. Configuration writes are taken throughout.
module first_fit_boundary_tag_allocator
  import ffbt_pkg::*;
#(
  parameter int HEAP_BYTES = DEF_HEAP_BYTES,
  parameter int TAG_BYTES  = DEF_TAG_BYTES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  start,
  output logic                  busy,
  input  logic                  func,
  input  logic [14:0]           request_size,
  input  logic [31:0]           payload_addr,
  output logic                  done,
  output logic [31:0]           payload_address,
  output logic                  success
);

  localparam int HEAP_WORDS = HEAP_BYTES / TAG_BYTES;
  localparam int HEAP_SPAN  = HEAP_WORDS * TAG_BYTES;
  localparam int TAG_W      = $clog2(HEAP_SPAN + 1);
  localparam int WORD_W     = $clog2(HEAP_WORDS);
  localparam int AW         = TAG_W + 1;

  logic [31:0]       heap_base;
  mem_ctl_t          ctl;
  logic [AW-1:0]     baddr;
  logic [AW-1:0]     word;
  logic [WORD_W-1:0] dword;
  logic [TAG_W-1:0]  wdata;
  logic [TAG_W-1:0]  rdata;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_HEAP_BASE) ? heap_base : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= '0;
    end else if (psel && penable && pwrite && pready && paddr == REG_HEAP_BASE) begin
      heap_base <= pwdata;
    end
  end

  ffbt_seq #(
    .HEAP_BYTES(HEAP_BYTES),
    .TAG_BYTES (TAG_BYTES)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .func           (func),
    .request_size   (request_size),
    .payload_addr   (payload_addr),
    .heap_base      (heap_base),
    .busy           (busy),
    .done           (done),
    .payload_address(payload_address),
    .success        (success),
    .ctl            (ctl),
    .baddr          (baddr),
    .dword          (dword),
    .wdata          (wdata),
    .rdata          (rdata),
    .word           (word)
  );

  ffbt_tagmem #(
    .HEAP_BYTES(HEAP_BYTES),
    .TAG_BYTES (TAG_BYTES)
  ) u_tagmem (
    .clk  (clk),
    .ctl  (ctl),
    .baddr(baddr),
    .dword(dword),
    .wdata(wdata),
    .rdata(rdata),
    .word (word)
  );

endmodule
